/* sv/i2cms_pkg.sv */
// Shared constants and codes of the I2C master transfer sequencer.
package i2cms_pkg;

   localparam int DEFAULT_STORE_DEPTH = 64;

   // Read/write bit of the address byte.
   localparam logic [7:0] READ_BIT = 8'h01;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_EVENT = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_WRITE    = 3'd1,
      ACT_START    = 3'd2,
      ACT_RESTART  = 3'd3,
      ACT_RX_ENTER = 3'd4,
      ACT_RX_BYTE  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NACK     = 2'd1,
      ST_ARB_LOST = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

endpackage

/* sv/i2cms_if.sv */
// Request and response channel interfaces of the I2C master transfer sequencer.
interface i2cms_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [5:0]  buf_index;
   logic [7:0]  buf_value;
   logic [6:0]  slave_address;
   logic [6:0]  prefix_len;
   logic [15:0] data_len;
   logic        is_write;
   logic        bus_busy;
   logic        got_nack;
   logic        arb_lost;
   logic [7:0]  rx_byte;

   modport source (
      output valid, operation, buf_index, buf_value, slave_address, prefix_len,
             data_len, is_write, bus_busy, got_nack, arb_lost, rx_byte,
      input  ready
   );
   modport sink (
      input  valid, operation, buf_index, buf_value, slave_address, prefix_len,
             data_len, is_write, bus_busy, got_nack, arb_lost, rx_byte,
      output ready
   );
endinterface

interface i2cms_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  bus_byte;
   logic        send_stop;
   logic        ack_disable;
   logic        done_res;
   logic [1:0]  status;
   logic [15:0] received_count;

   modport source (
      output valid, action, bus_byte, send_stop, ack_disable, done_res, status,
             received_count,
      input  ready
   );
   modport sink (
      input  valid, action, bus_byte, send_stop, ack_disable, done_res, status,
             received_count,
      output ready
   );
endinterface

/* sv/i2cms_store.sv */
// Transmit byte store with a registered prefetch of the next byte to send.
module i2cms_store #(
   parameter int STORE_DEPTH = i2cms_pkg::DEFAULT_STORE_DEPTH,
   localparam int AW = $clog2(STORE_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // write in the same cycle at the prefetch address is forwarded
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

/* sv/i2c_master_transfer_sequencer.sv */
// Top level of the I2C master transfer sequencer: request decode, sequencing and result register.
//
// Byte-level I2C master sequencer. Each request is a store load, a transfer start or a
// controller interrupt event, and each request yields exactly one response that tells the
// controller what to do next (send a byte, start or repeated start with an address byte,
// enter receive, hand over a received byte, generate stop) along with the ACK-disable
// setting, completion flag, status and received byte count. Throughput is one request per
// clock while the response channel does not stall. A request passes the request register,
// then the response register, with one pass of decision logic between; the next transmit byte
// comes from a prefetch register that always holds the store entry at the next send index,
// so a send never waits on the store read port. A start whose prefix plus write data does
// not fit in the store is answered with a too-long status and changes nothing. The store
// holds STORE_DEPTH bytes; entries read before being loaded return undefined data.
module i2c_master_transfer_sequencer #(
   parameter int STORE_DEPTH = i2cms_pkg::DEFAULT_STORE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   i2cms_req_if.sink   req_chan,
   i2cms_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(STORE_DEPTH);

   typedef struct packed {
      logic [1:0]  operation;
      logic [5:0]  buf_index;
      logic [7:0]  buf_value;
      logic [6:0]  slave_address;
      logic [6:0]  prefix_len;
      logic [15:0] data_len;
      logic        is_write;
      logic        bus_busy;
      logic        got_nack;
      logic        arb_lost;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      i2cms_pkg::action_type action;
      logic [7:0]            bus_byte;
      logic                  send_stop;
      logic                  ack_disable;
      logic                  done_res;
      i2cms_pkg::status_type status;
      logic [15:0]           received_count;
   } rsp_type;

   // request register
   logic    req_valid_ff;
   req_type req_ff;
   // response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   // sequencer state
   logic          master_mode_ff, master_mode_in;
   logic          transmit_mode_ff, transmit_mode_in;
   logic          ack_off_ff, ack_off_in;
   logic [6:0]    prefix_left_ff, prefix_left_in;
   logic [15:0]   write_left_ff, write_left_in;
   logic [15:0]   read_left_ff, read_left_in;
   logic [AW-1:0] next_index_ff, next_index_in;
   logic          restart_pending_ff, restart_pending_in;
   logic [7:0]    address_byte_ff, address_byte_in;
   logic [15:0]   rx_total_ff, rx_total_in;

   logic          advance;
   logic          store_wr;
   logic [7:0]    store_byte;
   logic [16:0]   total_len;
   logic          too_long;
   logic          start_ok;

   // the request register moves on when the response register is free or being drained
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         req_ff.operation     <= req_chan.operation;
         req_ff.buf_index     <= req_chan.buf_index;
         req_ff.buf_value     <= req_chan.buf_value;
         req_ff.slave_address <= req_chan.slave_address;
         req_ff.prefix_len    <= req_chan.prefix_len;
         req_ff.data_len      <= req_chan.data_len;
         req_ff.is_write      <= req_chan.is_write;
         req_ff.bus_busy      <= req_chan.bus_busy;
         req_ff.got_nack      <= req_chan.got_nack;
         req_ff.arb_lost      <= req_chan.arb_lost;
         req_ff.rx_byte       <= req_chan.rx_byte;
      end
   end

   // loads beyond the store are dropped
   assign store_wr = advance
                     && (i2cms_pkg::op_type'(req_ff.operation) == i2cms_pkg::OP_LOAD)
                     && (32'(req_ff.buf_index) < 32'(STORE_DEPTH));

   i2cms_store #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (AW'(req_ff.buf_index)),
      .wr_data (req_ff.buf_value),
      .rd_addr (next_index_in),
      .rd_data (store_byte)
   );

   // a read only needs room for its prefix
   assign total_len = 17'(req_ff.prefix_len)
                      + (req_ff.is_write ? 17'(req_ff.data_len) : 17'd0);
   assign too_long  = 32'(total_len) > 32'(STORE_DEPTH);
   assign start_ok  = !too_long;

   always_comb begin
      logic [15:0] read_dec;

      master_mode_in     = master_mode_ff;
      transmit_mode_in   = transmit_mode_ff;
      ack_off_in         = ack_off_ff;
      prefix_left_in     = prefix_left_ff;
      write_left_in      = write_left_ff;
      read_left_in       = read_left_ff;
      next_index_in      = next_index_ff;
      restart_pending_in = restart_pending_ff;
      address_byte_in    = address_byte_ff;
      rx_total_in        = rx_total_ff;
      read_dec           = (read_left_ff != 16'd0) ? read_left_ff - 16'd1 : 16'd0;

      rsp_in.action    = i2cms_pkg::ACT_NONE;
      rsp_in.bus_byte  = 8'd0;
      rsp_in.send_stop = 1'b0;
      rsp_in.done_res  = 1'b0;
      rsp_in.status    = i2cms_pkg::ST_OK;

      if (advance) begin
         unique case (i2cms_pkg::op_type'(req_ff.operation))
            i2cms_pkg::OP_LOAD: begin
               // store write happens in u_store
            end
            i2cms_pkg::OP_START: begin
               if (too_long) begin
                  rsp_in.status = i2cms_pkg::ST_TOO_LONG;
               end else begin
                  if (req_ff.bus_busy) begin
                     ack_off_in = 1'b0;
                  end
                  rx_total_in     = 16'd0;
                  next_index_in   = '0;
                  address_byte_in = {req_ff.slave_address, 1'b0};
                  prefix_left_in  = req_ff.prefix_len;
                  rsp_in.bus_byte = {req_ff.slave_address, 1'b0};
                  if (req_ff.is_write) begin
                     write_left_in      = req_ff.data_len;
                     read_left_in       = 16'd0;
                     restart_pending_in = 1'b0;
                  end else begin
                     write_left_in      = 16'd0;
                     read_left_in       = req_ff.data_len;
                     restart_pending_in = (req_ff.data_len != 16'd0)
                                          && (req_ff.prefix_len != 7'd0);
                     // no prefix: the first address byte already reads
                     if (req_ff.prefix_len == 7'd0) begin
                        rsp_in.bus_byte = {req_ff.slave_address, 1'b0}
                                          | i2cms_pkg::READ_BIT;
                     end
                  end
                  transmit_mode_in = 1'b1;
                  master_mode_in   = 1'b1;
                  // still holding the bus: repeated start
                  rsp_in.action = (master_mode_ff && !req_ff.bus_busy)
                                  ? i2cms_pkg::ACT_RESTART : i2cms_pkg::ACT_START;
               end
            end
            i2cms_pkg::OP_EVENT: begin
               if (master_mode_ff && transmit_mode_ff) begin
                  if (req_ff.got_nack) begin
                     master_mode_in     = 1'b0;
                     transmit_mode_in   = 1'b0;
                     prefix_left_in     = 7'd0;
                     write_left_in      = 16'd0;
                     read_left_in       = 16'd0;
                     restart_pending_in = 1'b0;
                     rsp_in.send_stop   = 1'b1;
                     rsp_in.status      = i2cms_pkg::ST_NACK;
                  end else if (prefix_left_ff != 7'd0) begin
                     prefix_left_in  = prefix_left_ff - 7'd1;
                     next_index_in   = next_index_ff + AW'(1);
                     rsp_in.bus_byte = store_byte;
                     rsp_in.action   = i2cms_pkg::ACT_WRITE;
                  end else if (write_left_ff != 16'd0) begin
                     write_left_in   = write_left_ff - 16'd1;
                     next_index_in   = next_index_ff + AW'(1);
                     rsp_in.bus_byte = store_byte;
                     rsp_in.action   = i2cms_pkg::ACT_WRITE;
                  end else if (read_left_ff != 16'd0) begin
                     if (restart_pending_ff) begin
                        restart_pending_in = 1'b0;
                        rsp_in.bus_byte    = address_byte_ff | i2cms_pkg::READ_BIT;
                        rsp_in.action      = i2cms_pkg::ACT_RESTART;
                     end else begin
                        ack_off_in       = (read_left_ff == 16'd1);
                        transmit_mode_in = 1'b0;
                        rsp_in.action    = i2cms_pkg::ACT_RX_ENTER;
                     end
                  end else begin
                     master_mode_in   = 1'b0;
                     transmit_mode_in = 1'b0;
                     rsp_in.send_stop = 1'b1;
                     rsp_in.done_res  = 1'b1;
                  end
               end else if (master_mode_ff) begin
                  // receive mode; empty count counts as the final byte
                  read_left_in = read_dec;
                  if (read_dec != 16'd0) begin
                     if (read_dec == 16'd1) begin
                        ack_off_in = 1'b1;
                     end
                  end else begin
                     master_mode_in   = 1'b0;
                     ack_off_in       = 1'b0;
                     rsp_in.send_stop = 1'b1;
                     rsp_in.done_res  = 1'b1;
                  end
                  if (rx_total_ff != 16'hFFFF) begin
                     rx_total_in = rx_total_ff + 16'd1;
                  end
                  rsp_in.bus_byte = req_ff.rx_byte;
                  rsp_in.action   = i2cms_pkg::ACT_RX_BYTE;
               end else if (req_ff.arb_lost) begin
                  prefix_left_in     = 7'd0;
                  write_left_in      = 16'd0;
                  read_left_in       = 16'd0;
                  restart_pending_in = 1'b0;
                  transmit_mode_in   = 1'b0;
                  rsp_in.status      = i2cms_pkg::ST_ARB_LOST;
               end
            end
            default: begin
               // unused operation code: no effect
            end
         endcase
      end

      rsp_in.ack_disable    = ack_off_in;
      rsp_in.received_count = rx_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_mode_ff     <= 1'b0;
         transmit_mode_ff   <= 1'b0;
         ack_off_ff         <= 1'b0;
         prefix_left_ff     <= 7'd0;
         write_left_ff      <= 16'd0;
         read_left_ff       <= 16'd0;
         next_index_ff      <= '0;
         restart_pending_ff <= 1'b0;
         address_byte_ff    <= 8'd0;
         rx_total_ff        <= 16'd0;
      end else begin
         master_mode_ff     <= master_mode_in;
         transmit_mode_ff   <= transmit_mode_in;
         ack_off_ff         <= ack_off_in;
         prefix_left_ff     <= prefix_left_in;
         write_left_ff      <= write_left_in;
         read_left_ff       <= read_left_in;
         next_index_ff      <= next_index_in;
         restart_pending_ff <= restart_pending_in;
         address_byte_ff    <= address_byte_in;
         rx_total_ff        <= rx_total_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.action         = rsp_ff.action;
   assign rsp_chan.bus_byte       = rsp_ff.bus_byte;
   assign rsp_chan.send_stop      = rsp_ff.send_stop;
   assign rsp_chan.ack_disable    = rsp_ff.ack_disable;
   assign rsp_chan.done_res       = rsp_ff.done_res;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.received_count = rsp_ff.received_count;

   // transmit mode only exists inside master mode
   a_tx_in_master: assert property (@(posedge clock) disable iff (reset)
      transmit_mode_ff |-> master_mode_ff)
      else $error("transmit mode set outside master mode");

   // prefix bytes are only pending while transmitting
   a_prefix_tx: assert property (@(posedge clock) disable iff (reset)
      (prefix_left_ff != 7'd0) |-> transmit_mode_ff)
      else $error("prefix bytes pending outside transmit mode");

   // an accepted start takes the bus and clears the receive count
   a_start_takes_bus: assert property (@(posedge clock) disable iff (reset)
      (advance && (i2cms_pkg::op_type'(req_ff.operation) == i2cms_pkg::OP_START)
       && start_ok)
      |=> (master_mode_ff && transmit_mode_ff && (rx_total_ff == 16'd0)))
      else $error("start did not enter master transmit");

   // a stop always leaves master mode
   a_stop_leaves_master: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_in.send_stop) |=> (!master_mode_ff && rsp_valid_ff))
      else $error("stop issued while master mode kept");

endmodule
